[rtl/core/bce_pkg.sv]
// ----------------------------------------------------------------------------
// bce_pkg
// shared constants, register map, binomial table and config bundle for the
// bezier curve evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

  localparam int T_WIDTH     = 17;
  localparam int VALUE_WIDTH = 32;
  localparam int SLOPE_WIDTH = 40;
  localparam int POINT_WIDTH = 32;
  localparam int DIFF_WIDTH  = POINT_WIDTH + 1;
  localparam int NUM_POINTS  = 7;
  localparam int IDX_WIDTH   = 4;

  // register map
  localparam logic [IDX_WIDTH-1:0] REG_DEGREE     = 4'd0;
  localparam logic [IDX_WIDTH-1:0] REG_POINT_0    = 4'd1;
  localparam logic [IDX_WIDTH-1:0] REG_POINT_LAST = 4'd7;

  localparam logic [2:0] DEGREE_RST = 3'd3;
  localparam logic [2:0] DEGREE_MIN = 3'd2;

  // pascal triangle rows 0..6
  localparam logic [4:0] BINOM_TAB [7][7] = '{
    '{5'd1, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd1, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd2, 5'd1,  5'd0,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd3, 5'd3,  5'd1,  5'd0,  5'd0, 5'd0},
    '{5'd1, 5'd4, 5'd6,  5'd4,  5'd1,  5'd0, 5'd0},
    '{5'd1, 5'd5, 5'd10, 5'd10, 5'd5,  5'd1, 5'd0},
    '{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6, 5'd1}
  };

  typedef struct packed {
    logic [2:0]                                  deg_eff;
    logic [NUM_POINTS-1:0][POINT_WIDTH-1:0]      point;
    logic [NUM_POINTS-2:0][DIFF_WIDTH-1:0]       diff;
  } cfg_t;

  // zero outside the triangle, which also masks unused terms
  function automatic logic [4:0] binom(input logic [2:0] n, input logic [2:0] k);
    logic [4:0] c;
    if (n < 3'd7 && k < 3'd7) begin
      c = BINOM_TAB[n][k];
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bce_cfg.sv]
// ----------------------------------------------------------------------------
// bce_cfg
// configuration registers, effective degree and registered point differences
// ----------------------------------------------------------------------------
`default_nettype none

module bce_cfg #(
  parameter int MAX_DEGREE = 6
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  input  wire logic [bce_pkg::IDX_WIDTH-1:0]      cfg_index,
  input  wire logic [bce_pkg::POINT_WIDTH-1:0]    cfg_data,
  output bce_pkg::cfg_t                           cfg
);

  localparam logic [2:0] DEG_MAX = 3'(MAX_DEGREE);

  logic [2:0]                                                      degree_r;
  logic [bce_pkg::NUM_POINTS-1:0][bce_pkg::POINT_WIDTH-1:0]        point_r;
  logic [bce_pkg::NUM_POINTS-2:0][bce_pkg::DIFF_WIDTH-1:0]         diff_r;
  logic [2:0]                                                      pidx;
  logic [2:0]                                                      deg_eff;

  assign pidx = 3'(cfg_index - bce_pkg::REG_POINT_0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= bce_pkg::DEGREE_RST;
      point_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == bce_pkg::REG_DEGREE) begin
        degree_r <= cfg_data[2:0];
      end else if (cfg_index <= bce_pkg::REG_POINT_LAST) begin
        point_r[pidx] <= cfg_data;
      end
    end
  end

  // exact 33-bit neighbor differences for the slope terms
  always_ff @(posedge clk) begin
    for (int i = 0; i < bce_pkg::NUM_POINTS - 1; i++) begin
      diff_r[i] <= {point_r[i+1][bce_pkg::POINT_WIDTH-1], point_r[i+1]}
                 - {point_r[i][bce_pkg::POINT_WIDTH-1], point_r[i]};
    end
  end

  always_comb begin
    if (degree_r < bce_pkg::DEGREE_MIN) begin
      deg_eff = bce_pkg::DEGREE_MIN;
    end else if (degree_r > DEG_MAX) begin
      deg_eff = DEG_MAX;
    end else begin
      deg_eff = degree_r;
    end
  end

  assign cfg.deg_eff = deg_eff;
  assign cfg.point   = point_r;
  assign cfg.diff    = diff_r;

endmodule

`default_nettype wire

[rtl/core/bce_powers.sv]
// ----------------------------------------------------------------------------
// bce_powers
// clamps t and builds t^k and (1-t)^k, one truncated product per power in each stage after the first
// ----------------------------------------------------------------------------
`default_nettype none

module bce_powers #(
  parameter int MAX_DEGREE = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic [MAX_DEGREE-1:0]                en,
  input  wire logic [bce_pkg::T_WIDTH-1:0]          t_param,
  output logic [MAX_DEGREE:0][FRAC_BITS:0]          t_pow,
  output logic [MAX_DEGREE:0][FRAC_BITS:0]          u_pow
);

  localparam int W  = FRAC_BITS + 1;
  localparam int NS = MAX_DEGREE;
  localparam int CW = (bce_pkg::T_WIDTH > W) ? bce_pkg::T_WIDTH : W;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [MAX_DEGREE:1][W-1:0] tp_r [NS];
  logic [MAX_DEGREE:1][W-1:0] up_r [NS];

  logic [CW-1:0]              t_ext;
  logic [W-1:0]               t_cl;
  logic [MAX_DEGREE:1][W-1:0] tp0_nxt;
  logic [MAX_DEGREE:1][W-1:0] up0_nxt;

  // stage 0: clamp t to one, first powers
  always_comb begin
    t_ext = CW'(t_param);
    if (t_ext > CW'(ONE)) begin
      t_cl = ONE;
    end else begin
      t_cl = W'(t_ext);
    end
    tp0_nxt    = '0;
    up0_nxt    = '0;
    tp0_nxt[1] = t_cl;
    up0_nxt[1] = ONE - t_cl;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tp_r[0] <= tp0_nxt;
      up_r[0] <= up0_nxt;
    end
  end

  // stage s builds power s+1 from power s and the first power (t or 1-t)
  for (genvar s = 1; s < NS; s++) begin : g_stage
    logic [2*W-1:0]             tprod;
    logic [2*W-1:0]             uprod;
    logic [MAX_DEGREE:1][W-1:0] tp_nxt;
    logic [MAX_DEGREE:1][W-1:0] up_nxt;

    always_comb begin
      tprod       = (2*W)'(tp_r[s-1][s]) * (2*W)'(tp_r[s-1][1]);
      uprod       = (2*W)'(up_r[s-1][s]) * (2*W)'(up_r[s-1][1]);
      tp_nxt      = tp_r[s-1];
      up_nxt      = up_r[s-1];
      tp_nxt[s+1] = tprod[FRAC_BITS +: W];
      up_nxt[s+1] = uprod[FRAC_BITS +: W];
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        tp_r[s] <= tp_nxt;
        up_r[s] <= up_nxt;
      end
    end
  end

  assign t_pow = {tp_r[NS-1], ONE};
  assign u_pow = {up_r[NS-1], ONE};

endmodule

`default_nettype wire

[rtl/core/bce_weights.sv]
// ----------------------------------------------------------------------------
// bce_weights
// bernstein basis weights for the value and the slope, two stages
// ----------------------------------------------------------------------------
`default_nettype none

module bce_weights #(
  parameter int MAX_DEGREE = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic [1:0]                           en,
  input  wire logic [2:0]                           deg,
  input  wire logic [MAX_DEGREE:0][FRAC_BITS:0]     t_pow,
  input  wire logic [MAX_DEGREE:0][FRAC_BITS:0]     u_pow,
  output logic [MAX_DEGREE:0][FRAC_BITS:0]          wv,
  output logic [MAX_DEGREE-1:0][FRAC_BITS:0]        ws
);

  localparam int W  = FRAC_BITS + 1;
  localparam int IW = $clog2(MAX_DEGREE + 1);

  logic [MAX_DEGREE:0][2*W-1:0]   pv_r, pv_nxt;
  logic [MAX_DEGREE-1:0][2*W-1:0] ps_r, ps_nxt;
  logic [MAX_DEGREE:0][W-1:0]     wv_r, wv_nxt;
  logic [MAX_DEGREE-1:0][W-1:0]   ws_r, ws_nxt;
  logic [2:0]                     deg_m1;

  assign deg_m1 = deg - 3'd1;

  // stage 1: (1-t)^(n-i) * t^i, exact
  always_comb begin
    logic [2:0] dv;
    logic [2:0] ds;
    dv = '0;
    ds = '0;
    for (int i = 0; i <= MAX_DEGREE; i++) begin
      dv        = deg - 3'(i);
      pv_nxt[i] = (3'(i) <= deg) ?
                  (2*W)'(u_pow[IW'(dv)]) * (2*W)'(t_pow[i]) : '0;
    end
    for (int i = 0; i < MAX_DEGREE; i++) begin
      ds        = deg_m1 - 3'(i);
      ps_nxt[i] = (3'(i) < deg) ?
                  (2*W)'(u_pow[IW'(ds)]) * (2*W)'(t_pow[i]) : '0;
    end
  end

  // stage 2: scale by the binomial and truncate
  always_comb begin
    logic [2*W+4:0] wp;
    wp = '0;
    for (int i = 0; i <= MAX_DEGREE; i++) begin
      wp        = (2*W+5)'(bce_pkg::binom(deg, 3'(i))) * (2*W+5)'(pv_r[i]);
      wv_nxt[i] = wp[FRAC_BITS +: W];
    end
    for (int i = 0; i < MAX_DEGREE; i++) begin
      wp        = (2*W+5)'(bce_pkg::binom(deg_m1, 3'(i))) * (2*W+5)'(ps_r[i]);
      ws_nxt[i] = wp[FRAC_BITS +: W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pv_r <= pv_nxt;
      ps_r <= ps_nxt;
    end
    if (en[1]) begin
      wv_r <= wv_nxt;
      ws_r <= ws_nxt;
    end
  end

  assign wv = wv_r;
  assign ws = ws_r;

endmodule

`default_nettype wire

[rtl/core/bce_combine.sv]
// ----------------------------------------------------------------------------
// bce_combine
// weighted point sums, degree scaling, rounding and saturation, five stages
// ----------------------------------------------------------------------------
`default_nettype none

module bce_combine #(
  parameter int MAX_DEGREE = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                      clk,
  input  wire logic [4:0]                                en,
  input  wire bce_pkg::cfg_t                             cfg,
  input  wire logic [MAX_DEGREE:0][FRAC_BITS:0]          wv,
  input  wire logic [MAX_DEGREE-1:0][FRAC_BITS:0]        ws,
  output logic signed [bce_pkg::VALUE_WIDTH-1:0]         curve_value,
  output logic signed [bce_pkg::SLOPE_WIDTH-1:0]         curve_slope,
  output logic                                           slope_saturated
);

  localparam int W   = FRAC_BITS + 1;
  localparam int MW  = W + bce_pkg::POINT_WIDTH;
  localparam int DW  = W + bce_pkg::DIFF_WIDTH;
  localparam int AW  = MW + 3;
  localparam int SW  = DW + 3;
  localparam int PW  = SW + 3;
  localparam int VW  = bce_pkg::VALUE_WIDTH;
  localparam int OW  = bce_pkg::SLOPE_WIDTH;
  localparam int NV  = MAX_DEGREE + 1;
  localparam int NPV = (NV + 1) / 2;
  localparam int NPS = (MAX_DEGREE + 1) / 2;
  localparam logic signed [AW:0] HALF_V = (AW+1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW:0] HALF_S = (PW+1)'(1) <<< (FRAC_BITS - 1);

  logic signed [MW-1:0] mv_r [NV];
  logic signed [DW-1:0] ms_r [MAX_DEGREE];
  logic signed [AW-1:0] sv_r [NPV];
  logic signed [SW-1:0] ss_r [NPS];
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [SW-1:0] dacc_r, dacc_nxt;
  logic signed [VW-1:0] val_r, val_nxt;
  logic signed [PW-1:0] sp_r;
  logic signed [VW-1:0] value_r;
  logic signed [OW-1:0] slope_r, slope_nxt;
  logic                 sat_r, sat_nxt;

  // stage 1: weight times point / difference
  for (genvar i = 0; i < NV; i++) begin : g_mv
    always_ff @(posedge clk) begin
      if (en[0]) begin
        mv_r[i] <= MW'($signed({1'b0, wv[i]})) * MW'($signed(cfg.point[i]));
      end
    end
  end

  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_ms
    always_ff @(posedge clk) begin
      if (en[0]) begin
        ms_r[i] <= DW'($signed({1'b0, ws[i]})) * DW'($signed(cfg.diff[i]));
      end
    end
  end

  // stage 2: pairwise sums
  for (genvar j = 0; j < NPV; j++) begin : g_sv
    logic signed [AW-1:0] sv_nxt;
    if (2*j + 1 < NV) begin : g_pair
      assign sv_nxt = AW'(mv_r[2*j]) + AW'(mv_r[2*j+1]);
    end else begin : g_single
      assign sv_nxt = AW'(mv_r[2*j]);
    end
    always_ff @(posedge clk) begin
      if (en[1]) begin
        sv_r[j] <= sv_nxt;
      end
    end
  end

  for (genvar j = 0; j < NPS; j++) begin : g_ss
    logic signed [SW-1:0] ss_nxt;
    if (2*j + 1 < MAX_DEGREE) begin : g_pair
      assign ss_nxt = SW'(ms_r[2*j]) + SW'(ms_r[2*j+1]);
    end else begin : g_single
      assign ss_nxt = SW'(ms_r[2*j]);
    end
    always_ff @(posedge clk) begin
      if (en[1]) begin
        ss_r[j] <= ss_nxt;
      end
    end
  end

  // stage 3: final sums over at most four partials
  always_comb begin
    acc_nxt  = '0;
    dacc_nxt = '0;
    for (int j = 0; j < NPV; j++) begin
      acc_nxt = acc_nxt + sv_r[j];
    end
    for (int j = 0; j < NPS; j++) begin
      dacc_nxt = dacc_nxt + ss_r[j];
    end
  end

  // stage 4: round and clip the value, scale the slope sum by the degree
  always_comb begin
    logic signed [AW:0]       vsum;
    logic signed [AW:0]       vsh;
    logic [AW-VW+1:0]         vhi;
    vsum = (AW+1)'(acc_r) + HALF_V;
    vsh  = vsum >>> FRAC_BITS;
    vhi  = vsh[AW:VW-1];
    if ((&vhi) || !(|vhi)) begin
      val_nxt = vsh[VW-1:0];
    end else if (vsh[AW]) begin
      val_nxt = {1'b1, {(VW-1){1'b0}}};
    end else begin
      val_nxt = {1'b0, {(VW-1){1'b1}}};
    end
  end

  // stage 5: round and clip the slope
  always_comb begin
    logic signed [PW:0]       ssum;
    logic signed [PW:0]       ssh;
    logic [PW-OW+1:0]         shi;
    ssum = (PW+1)'(sp_r) + HALF_S;
    ssh  = ssum >>> FRAC_BITS;
    shi  = ssh[PW:OW-1];
    if ((&shi) || !(|shi)) begin
      slope_nxt = ssh[OW-1:0];
      sat_nxt   = 1'b0;
    end else if (ssh[PW]) begin
      slope_nxt = {1'b1, {(OW-1){1'b0}}};
      sat_nxt   = 1'b1;
    end else begin
      slope_nxt = {1'b0, {(OW-1){1'b1}}};
      sat_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      acc_r  <= acc_nxt;
      dacc_r <= dacc_nxt;
    end
    if (en[3]) begin
      val_r <= val_nxt;
      sp_r  <= PW'(dacc_r) * PW'($signed({1'b0, cfg.deg_eff}));
    end
    if (en[4]) begin
      value_r <= val_r;
      slope_r <= slope_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign curve_value     = value_r;
  assign curve_slope     = slope_r;
  assign slope_saturated = sat_r;

endmodule

`default_nettype wire

[rtl/core/bezier_curve_eval.sv]
// ----------------------------------------------------------------------------
// bezier_curve_eval
// throughput: one item per cycle at any configured degree while results are taken
// stalls: a full output register holds, bubbles further up still close up
// reset: synchronous active low, degree back to 3, points to zero, pipe empty
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_curve_eval #(
  parameter int MAX_DEGREE = 6,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // input channel: curve parameter t
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [bce_pkg::T_WIDTH-1:0]            in_t_param,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [bce_pkg::VALUE_WIDTH-1:0]      out_curve_value,
  output logic signed [bce_pkg::SLOPE_WIDTH-1:0]      out_curve_slope,
  output logic                                        out_slope_saturated,
  // configuration write channel
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [bce_pkg::IDX_WIDTH-1:0]          cfg_index,
  input  wire logic [bce_pkg::POINT_WIDTH-1:0]        cfg_data
);

  // stage budget: power chain, two weight stages, five combine stages
  localparam int NP  = MAX_DEGREE;
  localparam int NW  = 2;
  localparam int NC  = 5;
  localparam int NST = NP + NW + NC;

  bce_pkg::cfg_t                      cfg;
  logic [MAX_DEGREE:0][FRAC_BITS:0]   t_pow;
  logic [MAX_DEGREE:0][FRAC_BITS:0]   u_pow;
  logic [MAX_DEGREE:0][FRAC_BITS:0]   wv;
  logic [MAX_DEGREE-1:0][FRAC_BITS:0] ws;

  logic [NST-1:0] valid_r;
  logic [NST-1:0] take;

  // config writes never stall
  assign cfg_ready = 1'b1;

  bce_cfg #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a stage loads when it is empty or its item moves on; the last stage
  // moves on when the result is taken. this lets bubbles close up behind
  // a stalled output instead of freezing the whole pipe
  always_comb begin
    take[NST-1] = !valid_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      take[k] = !valid_r[k] || take[k+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (take[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (take[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_ready  = take[0];
  assign out_valid = valid_r[NST-1];

  // t clamp and power chain
  bce_powers #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_powers (
    .clk     (clk),
    .en      (take[NP-1:0]),
    .t_param (in_t_param),
    .t_pow   (t_pow),
    .u_pow   (u_pow)
  );

  // basis weights for value and slope
  bce_weights #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_weights (
    .clk   (clk),
    .en    (take[NP+NW-1:NP]),
    .deg   (cfg.deg_eff),
    .t_pow (t_pow),
    .u_pow (u_pow),
    .wv    (wv),
    .ws    (ws)
  );

  // dot products, scaling, rounding, output register
  bce_combine #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_combine (
    .clk             (clk),
    .en              (take[NST-1:NP+NW]),
    .cfg             (cfg),
    .wv              (wv),
    .ws              (ws),
    .curve_value     (out_curve_value),
    .curve_slope     (out_curve_slope),
    .slope_saturated (out_slope_saturated)
  );

  // a clipped slope always sits on one of the two rails
  a_sat_at_rail : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slope_saturated |->
      (out_curve_slope == {1'b1, {(bce_pkg::SLOPE_WIDTH-1){1'b0}}}) ||
      (out_curve_slope == {1'b0, {(bce_pkg::SLOPE_WIDTH-1){1'b1}}}))
    else $error("saturated slope not at a rail");

  // input is refused only when every stage is full and the result is held
  a_ready_bubbles : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!(&valid_r) || out_ready))
    else $error("ready does not follow pipe occupancy");

  // effective degree stays within the supported range
  a_deg_range : assert property (@(posedge clk) disable iff (!rst_n)
    (cfg.deg_eff >= bce_pkg::DEGREE_MIN) && (cfg.deg_eff <= 3'(MAX_DEGREE)))
    else $error("effective degree out of range");

endmodule

`default_nettype wire
